// File: design/slist_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted record table.
package slist_pkg;

  localparam int ID_W   = 16;
  localparam int KEY_W  = 8;
  localparam int PAY_W  = 32;
  localparam int FILL_W = 6;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_DUMP   = 2'd3
  } act_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } rec_t;

  // Read address selection for the next record fetch.
  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_LO,
    ADDR_HI,
    ADDR_INC,
    ADDR_DEC
  } addr_sel_t;

  // Memory write selection.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DN,
    WR_NEW
  } wr_sel_t;

  typedef struct packed {
    logic      capture;
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      pos_ld;
    logic      pos_above;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      found_clr;
    logic      found_set;
    logic      out_load;
    logic      out_ok;
    logic      out_rec;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    act_t action;
    logic empty;
    logic full;
    logic key_ge;
    logic id_eq;
    logic d_zero;
    logic d_last;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// File: design/slist_dp.sv
`timescale 1ns / 1ps
// Datapath of the sorted record table: record memory, counters and result register.
module slist_dp #(
  parameter int DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_action,
  input  logic [slist_pkg::ID_W-1:0]  in_key_id,
  input  logic [slist_pkg::KEY_W-1:0] in_sort_key,
  input  logic [slist_pkg::PAY_W-1:0] in_payload,
  input  slist_pkg::cmd_t             cmd,
  output slist_pkg::sts_t             sts,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [slist_pkg::ID_W-1:0]  out_id,
  output logic [slist_pkg::KEY_W-1:0] out_key,
  output logic [slist_pkg::PAY_W-1:0] out_payload,
  output logic [slist_pkg::FILL_W-1:0] out_fill,
  output logic                        out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FILL_W = slist_pkg::FILL_W;

  slist_pkg::rec_t mem [DEPTH];

  slist_pkg::act_t            op_action_r;
  logic [slist_pkg::ID_W-1:0]  op_id_r;
  logic [slist_pkg::KEY_W-1:0] op_key_r;
  logic [slist_pkg::PAY_W-1:0] op_pay_r;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   d_r;
  logic [AW-1:0]   pos_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  slist_pkg::rec_t wr_data;
  slist_pkg::rec_t rd_data_r;
  logic            found_r;

  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [slist_pkg::ID_W-1:0]  out_id_r;
  logic [slist_pkg::KEY_W-1:0] out_key_r;
  logic [slist_pkg::PAY_W-1:0] out_pay_r;
  logic [slist_pkg::FILL_W-1:0] out_fill_r;
  logic                        out_last_r;

  assign cnt_m1 = count_r - CW'(1);

  always_comb begin
    unique case (cmd.addr_sel)
      slist_pkg::ADDR_LO:  rd_addr = '0;
      slist_pkg::ADDR_HI:  rd_addr = cnt_m1[AW-1:0];
      slist_pkg::ADDR_INC: rd_addr = d_r + AW'(1);
      slist_pkg::ADDR_DEC: rd_addr = d_r - AW'(1);
      default:             rd_addr = d_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = d_r;
    wr_data = rd_data_r;
    unique case (cmd.wr_sel)
      slist_pkg::WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = d_r + AW'(1);
      end
      slist_pkg::WR_DN: begin
        wr_en   = 1'b1;
        wr_addr = d_r - AW'(1);
      end
      slist_pkg::WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = '{id: op_id_r, key: op_key_r, pay: op_pay_r};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    d_r       <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_action_r <= slist_pkg::act_t'(in_action);
      op_id_r     <= in_key_id;
      op_key_r    <= in_sort_key;
      op_pay_r    <= in_payload;
    end
    if (cmd.pos_ld) begin
      pos_r <= cmd.pos_above ? d_r + AW'(1) : '0;
    end
    if (cmd.out_load) begin
      out_ok_r   <= cmd.out_ok;
      out_id_r   <= cmd.out_rec ? rd_data_r.id  : '0;
      out_key_r  <= cmd.out_rec ? rd_data_r.key : '0;
      out_pay_r  <= cmd.out_rec ? rd_data_r.pay : '0;
      out_fill_r <= FILL_W'(count_r);
      out_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= cnt_m1;
      end
      if (cmd.found_clr) begin
        found_r <= 1'b0;
      end else if (cmd.found_set) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.action   = op_action_r;
    sts.empty    = (count_r == '0);
    sts.full     = (count_r == CW'(DEPTH));
    sts.key_ge   = (rd_data_r.key >= op_key_r);
    sts.id_eq    = (rd_data_r.id == op_id_r);
    sts.d_zero   = (d_r == '0);
    sts.d_last   = (CW'(d_r) == cnt_m1);
    sts.found    = found_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_id      = out_id_r;
  assign out_key     = out_key_r;
  assign out_payload = out_pay_r;
  assign out_fill    = out_fill_r;
  assign out_last    = out_last_r;

endmodule

// File: design/slist_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the sorted record table.
module slist_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  slist_pkg::sts_t sts,
  output slist_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_FIN,
    S_RESP,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_ok_r, resp_ok_nxt;
  logic   resp_rec_r, resp_rec_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    resp_ok_nxt  = resp_ok_r;
    resp_rec_nxt = resp_rec_r;
    cmd          = '0;
    cmd.addr_sel = slist_pkg::ADDR_HOLD;
    cmd.wr_sel   = slist_pkg::WR_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end

      S_START: begin
        resp_ok_nxt  = 1'b0;
        resp_rec_nxt = 1'b0;
        unique case (sts.action)
          slist_pkg::ACT_INSERT: begin
            if (sts.full) begin
              state_nxt = S_RESP;
            end else if (sts.empty) begin
              cmd.pos_ld = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              cmd.addr_sel = slist_pkg::ADDR_HI;
              state_nxt    = S_RUN;
            end
          end
          slist_pkg::ACT_DELETE, slist_pkg::ACT_LOOKUP: begin
            if (sts.empty) begin
              state_nxt = S_RESP;
            end else begin
              cmd.addr_sel  = slist_pkg::ADDR_LO;
              cmd.found_clr = 1'b1;
              state_nxt     = S_RUN;
            end
          end
          default: begin
            if (sts.empty) begin
              state_nxt = S_RESP;
            end else begin
              cmd.addr_sel = slist_pkg::ADDR_LO;
              state_nxt    = S_DUMP;
            end
          end
        endcase
      end

      S_RUN: begin
        unique case (sts.action)
          slist_pkg::ACT_INSERT: begin
            if (sts.key_ge) begin
              cmd.wr_sel = slist_pkg::WR_UP;
              if (sts.d_zero) begin
                cmd.pos_ld = 1'b1;
                state_nxt  = S_FIN;
              end else begin
                cmd.addr_sel = slist_pkg::ADDR_DEC;
              end
            end else begin
              cmd.pos_ld    = 1'b1;
              cmd.pos_above = 1'b1;
              state_nxt     = S_FIN;
            end
          end
          slist_pkg::ACT_DELETE: begin
            if (sts.found) begin
              cmd.wr_sel = slist_pkg::WR_DN;
            end else if (sts.id_eq) begin
              cmd.found_set = 1'b1;
            end
            if (sts.d_last) begin
              if (sts.found || sts.id_eq) begin
                cmd.cnt_dec = 1'b1;
                resp_ok_nxt = 1'b1;
              end
              state_nxt = S_RESP;
            end else begin
              cmd.addr_sel = slist_pkg::ADDR_INC;
            end
          end
          default: begin
            // Lookup holds the read address on a hit so the record stays
            // in the read register for the response.
            if (sts.id_eq) begin
              resp_ok_nxt  = 1'b1;
              resp_rec_nxt = 1'b1;
              state_nxt    = S_RESP;
            end else if (sts.d_last) begin
              state_nxt = S_RESP;
            end else begin
              cmd.addr_sel = slist_pkg::ADDR_INC;
            end
          end
        endcase
      end

      S_FIN: begin
        cmd.wr_sel  = slist_pkg::WR_NEW;
        cmd.cnt_inc = 1'b1;
        resp_ok_nxt = 1'b1;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = resp_ok_r;
          cmd.out_rec  = resp_rec_r;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_DUMP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = 1'b1;
          cmd.out_rec  = 1'b1;
          cmd.out_last = sts.d_last;
          if (sts.d_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.addr_sel = slist_pkg::ADDR_INC;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      resp_ok_r  <= 1'b0;
      resp_rec_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      resp_ok_r  <= resp_ok_nxt;
      resp_rec_r <= resp_rec_nxt;
    end
  end

endmodule

// File: design/sorted_list_insert_delete_lookup.sv
`timescale 1ns / 1ps
// The time from acceptance to the result beat grows with the number of records read;
// a full-table insert or an operation on an empty table reads no record.
// Dump delivers one beat per cycle while the consumer does not stall.
// One item is in work at a time; the record memory's single read port sets the scan pace.
// Reset (rst_n low, synchronous) empties the table and drops any pending result beat.
module sorted_list_insert_delete_lookup #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [slist_pkg::ID_W-1:0]   in_key_id,
  input  logic [slist_pkg::KEY_W-1:0]  in_sort_key,
  input  logic [slist_pkg::PAY_W-1:0]  in_payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic [slist_pkg::ID_W-1:0]   out_id,
  output logic [slist_pkg::KEY_W-1:0]  out_key,
  output logic [slist_pkg::PAY_W-1:0]  out_payload,
  output logic [slist_pkg::FILL_W-1:0] out_fill,
  output logic                         out_last
);

  // The controller sequences each operation. Inserts walk the table from
  // the top down, moving every record whose key is not smaller up by one
  // slot, and drop the new record into the gap. Deletes walk from the
  // bottom up and, once the matching id has been seen, move each later
  // record down by one slot. Lookups stop at the first id match. The
  // datapath reads one record per cycle, so a scan overlaps the fetch of
  // the next record with the move of the current one. Record storage
  // itself is not cleared at reset, since only entries below the count
  // are ever read.
  slist_pkg::cmd_t cmd;
  slist_pkg::sts_t sts;

  slist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The result register in the datapath frees the input side: a new
  // beat is accepted while the previous result still waits to be taken.
  slist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_action),
    .in_key_id   (in_key_id),
    .in_sort_key (in_sort_key),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_ok      (out_ok),
    .out_id      (out_id),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_fill    (out_fill),
    .out_last    (out_last)
  );

endmodule

// File: design/slist_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted record table, bound to the top level.
module slist_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_ok,
  input logic [slist_pkg::ID_W-1:0]   out_id,
  input logic [slist_pkg::KEY_W-1:0]  out_key,
  input logic [slist_pkg::PAY_W-1:0]  out_payload,
  input logic                         out_last
);

  // A stalled result beat stays up with its contents unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_id) && $stable(out_key)
      && $stable(out_payload) && $stable(out_ok) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A refused or missed operation carries no record contents.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_id == '0 && out_key == '0 && out_payload == '0)
    else $error("failed result carries record data");

  // Only a dump gives more than one beat, and each of its records is valid.
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_ok)
    else $error("non-final beat without ok");

  // While a dump is still in flight no new item is taken.
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("item accepted in the middle of a dump");

endmodule

bind sorted_list_insert_delete_lookup slist_chk u_slist_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_ok      (out_ok),
  .out_id      (out_id),
  .out_key     (out_key),
  .out_payload (out_payload),
  .out_last    (out_last)
);

// File: dv/tb_sorted_list_insert_delete_lookup.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted record table: queued stimulus, clocked driver and monitor.
module tb_sorted_list_insert_delete_lookup;

  localparam int DEPTH = 32;
  // Longest quiet stretch of a correct run: a full shift, the longest receiver stall run
  // and the longest sender gap, taken many times over.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 160;

  // One input item as queued for the driver. hold_for_drain makes the driver wait
  // until every expected beat has come back before presenting the item.
  typedef struct {
    slist_pkg::act_t action;
    logic [15:0]     id;
    logic [7:0]      key;
    logic [31:0]     pay;
    bit              hold_for_drain;
  } table_op_t;

  // One expected result beat.
  typedef struct {
    logic        ok;
    logic [15:0] id;
    logic [7:0]  key;
    logic [31:0] pay;
    logic [5:0]  fill;
    logic        fin;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = slist_pkg::ACT_INSERT;
  logic [15:0] in_key_id = '0;
  logic [7:0]  in_sort_key = '0;
  logic [31:0] in_payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [15:0] out_id;
  logic [7:0]  out_key;
  logic [31:0] out_payload;
  logic [5:0]  out_fill;
  logic        out_last;

  sorted_list_insert_delete_lookup #(.DEPTH(DEPTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_key_id   (in_key_id),
    .in_sort_key (in_sort_key),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_ok      (out_ok),
    .out_id      (out_id),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_fill    (out_fill),
    .out_last    (out_last)
  );

  always #4 clk = ~clk;

  // Items waiting to be driven, and the beats the block still owes us.
  table_op_t    pending_ops[$];
  result_beat_t owed_beats[$];

  // Our own copy of the table contents, kept in sorted order.
  slist_pkg::rec_t shadow_recs[$];

  // The generator keeps a rough view of the table (which ids are stored) so that
  // it can aim deletes and lookups at ids that hit.
  logic [15:0] gen_ids[$];
  int          random_count = 0;

  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic result_beat_t make_beat(logic ok, slist_pkg::rec_t r, logic fin);
    result_beat_t b;
    b.ok   = ok;
    b.id   = r.id;
    b.key  = r.key;
    b.pay  = r.pay;
    b.fill = 6'(shadow_recs.size());
    b.fin  = fin;
    return b;
  endfunction

  // Applies one accepted item to the shadow table and appends the beats it must produce.
  task automatic run_table_op(input table_op_t op);
    int              pos;
    int              i;
    slist_pkg::rec_t r;
    slist_pkg::rec_t none;
    none = '0;
    pos = -1;
    if (op.action == slist_pkg::ACT_DELETE || op.action == slist_pkg::ACT_LOOKUP) begin
      // Delete and lookup both go for the first match in sorted order.
      for (i = 0; i < shadow_recs.size(); i++) begin
        if (pos < 0 && shadow_recs[i].id == op.id) pos = i;
      end
    end
    case (op.action)
      slist_pkg::ACT_INSERT: begin
        if (shadow_recs.size() >= DEPTH) begin
          owed_beats.push_back(make_beat(1'b0, none, 1'b1));
        end else begin
          // New record lands ahead of any record with an equal key.
          pos = 0;
          while (pos < shadow_recs.size() && shadow_recs[pos].key < op.key) pos++;
          r.id  = op.id;
          r.key = op.key;
          r.pay = op.pay;
          shadow_recs.insert(pos, r);
          owed_beats.push_back(make_beat(1'b1, none, 1'b1));
        end
      end
      slist_pkg::ACT_DELETE: begin
        if (pos >= 0) shadow_recs.delete(pos);
        owed_beats.push_back(make_beat(pos >= 0, none, 1'b1));
      end
      slist_pkg::ACT_LOOKUP: begin
        if (pos >= 0) owed_beats.push_back(make_beat(1'b1, shadow_recs[pos], 1'b1));
        else owed_beats.push_back(make_beat(1'b0, none, 1'b1));
      end
      default: begin
        // Dump of an empty table still gives one beat, marked as not found.
        if (shadow_recs.size() == 0) begin
          owed_beats.push_back(make_beat(1'b0, none, 1'b1));
        end else begin
          for (i = 0; i < shadow_recs.size(); i++) begin
            owed_beats.push_back(make_beat(1'b1, shadow_recs[i], i == shadow_recs.size() - 1));
          end
        end
      end
    endcase
  endtask

  // Queues one item and keeps the generator's view of stored ids in step.
  task automatic queue_op(input slist_pkg::act_t action, input logic [15:0] id,
                          input logic [7:0] key, input logic [31:0] pay, input bit hold);
    table_op_t op;
    int        i;
    int        hit;
    op.action = action;
    op.id = id;
    op.key = key;
    op.pay = pay;
    op.hold_for_drain = hold;
    pending_ops.push_back(op);
    hit = -1;
    if (action == slist_pkg::ACT_INSERT && gen_ids.size() < DEPTH) gen_ids.push_back(id);
    if (action == slist_pkg::ACT_DELETE) begin
      for (i = 0; i < gen_ids.size(); i++) begin
        if (hit < 0 && gen_ids[i] == id) hit = i;
      end
      if (hit >= 0) gen_ids.delete(hit);
    end
  endtask

  // One random item, with the action picked by the given weights.
  task automatic queue_random_op(input int w_ins, input int w_del, input int w_look,
                                 input int w_dump);
    int              roll;
    slist_pkg::act_t action;
    logic [15:0]     id;
    logic [7:0]      key;
    logic [31:0]     pay;
    roll = $urandom_range(0, w_ins + w_del + w_look + w_dump - 1);
    if (roll < w_ins) action = slist_pkg::ACT_INSERT;
    else if (roll < w_ins + w_del) action = slist_pkg::ACT_DELETE;
    else if (roll < w_ins + w_del + w_look) action = slist_pkg::ACT_LOOKUP;
    else action = slist_pkg::ACT_DUMP;

    // Ids: mostly stored ones or a small pool that collides, sometimes the full range.
    roll = $urandom_range(0, 9);
    if (action != slist_pkg::ACT_INSERT && gen_ids.size() > 0 && roll < 7)
      id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    else if (roll < 8) id = 16'($urandom_range(0, 7));
    else if (roll == 8) id = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    else id = 16'($urandom_range(0, 65535));

    // Keys cluster on the extremes and on a few middle values so equal keys are common.
    case ($urandom_range(0, 4))
      0: key = 8'h00;
      1: key = 8'hFF;
      2: key = 8'h80 + 8'($urandom_range(0, 2));
      default: key = 8'($urandom_range(0, 255));
    endcase

    case ($urandom_range(0, 7))
      0: pay = 32'h0000_0000;
      1: pay = 32'hFFFF_FFFF;
      default: pay = $urandom;
    endcase

    queue_op(action, id, key, pay, $urandom_range(0, 24) == 0);
    random_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("result beat field %s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Driver. A new item goes out only when the current beat has been taken or
  // nothing is shown; a stalled beat keeps its payload. The sender runs in
  // bursts of random length separated by random gaps.
  table_op_t cur_op;
  int        burst_left = 4;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) run_table_op(cur_op);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].hold_for_drain && owed_beats.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          in_action   <= cur_op.action;
          in_key_id   <= cur_op.id;
          in_sort_key <= cur_op.key;
          in_payload  <= cur_op.pay;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 2);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each taken beat is checked against the oldest owed beat. The stall
  // pattern switches between no stalls, scattered stalls and long stall runs.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;
  result_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_beats.size() == 0) begin
        $error("result beat with nothing owed: id 0x%0h fill %0d", out_id, out_fill);
        mismatches++;
      end else begin
        want = owed_beats.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_ok));
        check_field("out_id", 32'(want.id), 32'(out_id));
        check_field("out_key", 32'(want.key), 32'(out_key));
        check_field("out_payload", want.pay, out_payload);
        check_field("fill", 32'(want.fill), 32'(out_fill));
        check_field("last", 32'(want.fin), 32'(out_last));
      end
    end

    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_run = $urandom_range(1, 16);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sorted_list_insert_delete_lookup NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  int phase = 0;

  initial begin
    // Directed part: empty-table cases, extremes, equal keys, duplicate ids, misses.
    queue_op(slist_pkg::ACT_DUMP, 16'h0000, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_LOOKUP, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'hFFFF, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(slist_pkg::ACT_INSERT, 16'h0000, 8'h00, 32'h0000_0000, 1'b0);
    queue_op(slist_pkg::ACT_INSERT, 16'h1234, 8'h80, 32'hA5A5_A5A5, 1'b0);
    queue_op(slist_pkg::ACT_INSERT, 16'h5678, 8'h80, 32'h5A5A_5A5A, 1'b0);
    queue_op(slist_pkg::ACT_INSERT, 16'h1234, 8'h07, 32'h0BAD_F00D, 1'b0);
    queue_op(slist_pkg::ACT_DUMP, 16'h0000, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_LOOKUP, 16'h1234, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_LOOKUP, 16'hFFFF, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_LOOKUP, 16'hBEEF, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'h1234, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_LOOKUP, 16'h1234, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'hBEEF, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DUMP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'h0000, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'hFFFF, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'h1234, 8'h00, 32'h0, 1'b0);
    queue_op(slist_pkg::ACT_DELETE, 16'h5678, 8'h00, 32'h0, 1'b0);
    // The sender waits for the table to go quiet before this one.
    queue_op(slist_pkg::ACT_DUMP, 16'h0000, 8'h00, 32'h0, 1'b1);

    // Random part in phases: fill up to full and past it, drain, then mixed traffic.
    while (random_count < RANDOM_ITEMS) begin
      case (phase % 3)
        0: begin
          while (gen_ids.size() < DEPTH) queue_random_op(80, 5, 10, 5);
          // Inserts into a full table must be refused.
          repeat ($urandom_range(2, 4)) queue_random_op(1, 0, 0, 0);
          queue_random_op(0, 0, 0, 1);
        end
        1: begin
          while (gen_ids.size() > $urandom_range(0, 3)) queue_random_op(5, 70, 15, 10);
        end
        default: begin
          repeat ($urandom_range(20, 40)) queue_random_op(30, 30, 30, 10);
        end
      endcase
      phase++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every item out, every owed beat back, then a latency's worth of quiet.
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_sorted_list_insert_delete_lookup OK");
    end else begin
      $display("tb_sorted_list_insert_delete_lookup NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/slist_pkg.sv
design/slist_dp.sv
design/slist_ctrl.sv
design/sorted_list_insert_delete_lookup.sv
design/slist_chk.sv
dv/tb_sorted_list_insert_delete_lookup.sv
